// ===== hw/rtl/frame_average_accumulator_assert.svh =====
// Assertion macros shared by the frame averaging block.
// Each macro checks a property on the rising edge of clk, held off during reset.
`ifndef FRAME_AVERAGE_ACCUMULATOR_ASSERT_SVH
`define FRAME_AVERAGE_ACCUMULATOR_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define FAA_ASSERT_SAME(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("frame averaging check failed");

// The consequent must hold in the cycle after the antecedent.
`define FAA_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("frame averaging check failed");

`endif

// ===== hw/rtl/faa_pkg.sv =====
package faa_pkg;

	// Store and field sizes.
	localparam int PIXELS_MAX = 65536;
	localparam int FRAMES_MAX = 256;
	localparam int ADDR_W     = $clog2(PIXELS_MAX);
	localparam int PIX_W      = 16;
	localparam int SUM_W      = 24;
	localparam int DIVISOR_W  = 9;
	localparam int PCOUNT_W   = 17;
	localparam int FIDX_W     = 8;
	localparam int CNT_W      = $clog2(SUM_W + 1);

	// Configuration register indexes.
	localparam logic REG_FRAME_COUNT = 1'b0;
	localparam logic REG_PIXEL_COUNT = 1'b1;

	// Sequencer states.
	typedef enum logic [1:0] {
		S_IDLE,
		S_SUM,
		S_DIV,
		S_OUT
	} state_t;

	// Request to the divider.
	typedef struct packed {
		logic                 start;
		logic [SUM_W-1:0]     dividend;
		logic [DIVISOR_W-1:0] divisor;
	} div_req_t;

	// Response from the divider.
	typedef struct packed {
		logic             done;
		logic [PIX_W-1:0] quotient;
	} div_rsp_t;

endpackage

// ===== hw/rtl/faa_ram.sv =====
module faa_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 65536
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// One write port and one registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== hw/rtl/faa_div.sv =====
module faa_div (
	input  logic              clk,
	input  logic              arst_n,
	input  faa_pkg::div_req_t req,
	output faa_pkg::div_rsp_t rsp
);

	logic                          busy_q;
	logic                          done_q;
	logic [faa_pkg::CNT_W-1:0]     cnt_q;
	logic [faa_pkg::SUM_W-1:0]     quo_q;
	logic [faa_pkg::DIVISOR_W-1:0] rem_q;
	logic [faa_pkg::DIVISOR_W-1:0] div_q;
	logic [faa_pkg::DIVISOR_W:0]   trial;
	logic [faa_pkg::DIVISOR_W:0]   diff;
	logic                          fits;
	logic [faa_pkg::DIVISOR_W-1:0] rem_next;

	// One restoring step: shift in the next dividend bit and try a subtract.
	always_comb begin
		trial    = {rem_q, quo_q[faa_pkg::SUM_W-1]};
		diff     = trial - {1'b0, div_q};
		fits     = trial >= {1'b0, div_q};
		rem_next = fits ? diff[faa_pkg::DIVISOR_W-1:0] : trial[faa_pkg::DIVISOR_W-1:0];
	end

	// Step counter; done pulses for one cycle after the last step.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= faa_pkg::CNT_W'(faa_pkg::SUM_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - faa_pkg::CNT_W'(1);
				if (cnt_q == faa_pkg::CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Quotient and remainder registers; the quotient holds until the next start.
	always_ff @(posedge clk) begin
		if (req.start) begin
			quo_q <= req.dividend;
			rem_q <= '0;
			div_q <= req.divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[faa_pkg::SUM_W-2:0], fits};
			rem_q <= rem_next;
		end
	end

	assign rsp.done     = done_q;
	assign rsp.quotient = quo_q[faa_pkg::PIX_W-1:0];

endmodule

// ===== hw/rtl/frame_average_accumulator.sv =====
// Frame averaging: per-pixel sums kept in a 64K x 24 RAM, averaged on the last frame.
// Accumulating frames: an item is accepted, then RAM read and write back, before the next is taken.
// Last frame: a pixel passes SUM, DIV and OUT; its result is valid once OUT loads it, and
// the next pixel is taken after that; the radix-2 divider takes 24 steps per pixel.
// Reset clears both counters and sets frame_count to 2 and pixel_count to 65536.
// The sum RAM is not cleared; the first frame of each run overwrites it unless it is also the last.
`include "frame_average_accumulator_assert.svh"

module frame_average_accumulator (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic                         cfg_index,
	input  logic [faa_pkg::PCOUNT_W-1:0] cfg_data,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [faa_pkg::PIX_W-1:0]    pixel,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [faa_pkg::PIX_W-1:0]    average,
	output logic                         frame_end
);

	faa_pkg::state_t state_q, state_d;

	logic [faa_pkg::DIVISOR_W-1:0] frame_count_q;
	logic [faa_pkg::PCOUNT_W-1:0]  pixel_count_q;
	logic [faa_pkg::ADDR_W-1:0]    pixel_index_q;
	logic [faa_pkg::FIDX_W-1:0]    frame_index_q;

	logic [faa_pkg::PIX_W-1:0]     pixel_s1;
	logic [faa_pkg::ADDR_W-1:0]    slot_s1;
	logic                          first_s1;
	logic                          last_frame_s1;
	logic                          last_pixel_s1;
	logic [faa_pkg::DIVISOR_W-1:0] divisor_s1;

	logic                          out_valid_q;
	logic [faa_pkg::PIX_W-1:0]     average_q;
	logic                          frame_end_q;

	logic [faa_pkg::DIVISOR_W-1:0] nf;
	logic [faa_pkg::PCOUNT_W-1:0]  np;
	logic                          last_pixel;
	logic                          last_frame;
	logic                          in_accept;
	logic                          ram_we;
	logic [faa_pkg::SUM_W-1:0]     ram_rdata;
	logic [faa_pkg::SUM_W-1:0]     sum;
	logic                          out_load;
	logic                          div_start;
	faa_pkg::div_req_t             div_req;
	faa_pkg::div_rsp_t             div_rsp;

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_count_q <= faa_pkg::DIVISOR_W'(2);
			pixel_count_q <= faa_pkg::PCOUNT_W'(faa_pkg::PIXELS_MAX);
		end else if (cfg_we) begin
			unique case (cfg_index)
				faa_pkg::REG_FRAME_COUNT: frame_count_q <= cfg_data[faa_pkg::DIVISOR_W-1:0];
				faa_pkg::REG_PIXEL_COUNT: pixel_count_q <= cfg_data;
			endcase
		end
	end

	// Effective counts: zero acts as one, large values saturate.
	always_comb begin
		priority if (frame_count_q == '0) begin
			nf = faa_pkg::DIVISOR_W'(1);
		end else if (frame_count_q > faa_pkg::DIVISOR_W'(faa_pkg::FRAMES_MAX)) begin
			nf = faa_pkg::DIVISOR_W'(faa_pkg::FRAMES_MAX);
		end else begin
			nf = frame_count_q;
		end
		priority if (pixel_count_q == '0) begin
			np = faa_pkg::PCOUNT_W'(1);
		end else if (pixel_count_q > faa_pkg::PCOUNT_W'(faa_pkg::PIXELS_MAX)) begin
			np = faa_pkg::PCOUNT_W'(faa_pkg::PIXELS_MAX);
		end else begin
			np = pixel_count_q;
		end
		last_pixel = {1'b0, pixel_index_q} >= (np - faa_pkg::PCOUNT_W'(1));
		last_frame = {1'b0, frame_index_q} >= (nf - faa_pkg::DIVISOR_W'(1));
	end

	assign in_accept = in_valid && in_ready;

	// Position counters advance on every input transfer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pixel_index_q <= '0;
			frame_index_q <= '0;
		end else if (in_accept) begin
			if (last_pixel) begin
				pixel_index_q <= '0;
				frame_index_q <= last_frame ? '0 : frame_index_q + faa_pkg::FIDX_W'(1);
			end else begin
				pixel_index_q <= pixel_index_q + faa_pkg::ADDR_W'(1);
			end
		end
	end

	// Item captured at its transfer, held until its work is done.
	always_ff @(posedge clk) begin
		if (in_accept) begin
			pixel_s1      <= pixel;
			slot_s1       <= pixel_index_q;
			first_s1      <= frame_index_q == '0;
			last_frame_s1 <= last_frame;
			last_pixel_s1 <= last_pixel;
			divisor_s1    <= nf;
		end
	end

	// Sum RAM: read at the transfer, written back in the following cycle except on the last frame.
	faa_ram #(
		.WIDTH(faa_pkg::SUM_W),
		.DEPTH(faa_pkg::PIXELS_MAX)
	) u_sum_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(slot_s1),
		.wdata(sum),
		.re   (in_accept),
		.raddr(pixel_index_q),
		.rdata(ram_rdata)
	);

	// The first frame of a run ignores the stored value.
	assign sum = first_s1 ? faa_pkg::SUM_W'(pixel_s1)
	                      : ram_rdata + faa_pkg::SUM_W'(pixel_s1);

	assign div_req = '{start: div_start, dividend: sum, divisor: divisor_s1};

	faa_div u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (div_req),
		.rsp   (div_rsp)
	);

	// Sequencer state register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= faa_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and control.
	always_comb begin
		state_d   = state_q;
		in_ready  = 1'b0;
		ram_we    = 1'b0;
		div_start = 1'b0;
		out_load  = 1'b0;
		unique case (state_q)
			faa_pkg::S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					state_d = faa_pkg::S_SUM;
				end
			end
			faa_pkg::S_SUM: begin
				if (last_frame_s1) begin
					div_start = 1'b1;
					state_d   = faa_pkg::S_DIV;
				end else begin
					ram_we  = 1'b1;
					state_d = faa_pkg::S_IDLE;
				end
			end
			faa_pkg::S_DIV: begin
				if (div_rsp.done) begin
					state_d = faa_pkg::S_OUT;
				end
			end
			faa_pkg::S_OUT: begin
				if (!out_valid_q || out_ready) begin
					out_load = 1'b1;
					state_d  = faa_pkg::S_IDLE;
				end
			end
			default: state_d = faa_pkg::S_IDLE;
		endcase
	end

	// Output register; a result waits here while the next pixel is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			average_q   <= div_rsp.quotient;
			frame_end_q <= last_pixel_s1;
		end
	end

	assign out_valid = out_valid_q;
	assign average   = average_q;
	assign frame_end = frame_end_q;

	// Checks on sequencing.
	`FAA_ASSERT_NEXT(a_accept_then_sum, in_accept, state_q == faa_pkg::S_SUM)
	`FAA_ASSERT_SAME(a_no_writeback_last, ram_we, !last_frame_s1)
	`FAA_ASSERT_SAME(a_div_done_in_div, div_rsp.done, state_q == faa_pkg::S_DIV)
	`FAA_ASSERT_NEXT(a_out_wait, state_q == faa_pkg::S_OUT && out_valid_q && !out_ready, state_q == faa_pkg::S_OUT)

endmodule
